### rtl/iatr_pkg.sv
package iatr_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [3:0] ADDR_PORT_A  = 4'd0;
    localparam logic [3:0] ADDR_PORT_B  = 4'd1;
    localparam logic [3:0] ADDR_DIR_A   = 4'd2;
    localparam logic [3:0] ADDR_DIR_B   = 4'd3;
    localparam logic [3:0] ADDR_TA_LO   = 4'd4;
    localparam logic [3:0] ADDR_TA_HI   = 4'd5;
    localparam logic [3:0] ADDR_TB_LO   = 4'd6;
    localparam logic [3:0] ADDR_TB_HI   = 4'd7;
    localparam logic [3:0] ADDR_CLK_0   = 4'd8;
    localparam logic [3:0] ADDR_CLK_1   = 4'd9;
    localparam logic [3:0] ADDR_CLK_2   = 4'd10;
    localparam logic [3:0] ADDR_CLK_3   = 4'd11;
    localparam logic [3:0] ADDR_SERIAL  = 4'd12;
    localparam logic [3:0] ADDR_ICR     = 4'd13;
    localparam logic [3:0] ADDR_CTRL_A  = 4'd14;
    localparam logic [3:0] ADDR_CTRL_B  = 4'd15;

    localparam int CTL_START_BIT   = 0;
    localparam int CTL_ONESHOT_BIT = 3;
    localparam int CTL_LOAD_BIT    = 4;
    localparam int ICR_SET_BIT     = 7;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] address;
        logic [7:0] write_data;
        logic [7:0] tick_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
    } t_out_item;

    typedef struct packed {
        logic       tick;
        logic       wr_lo;
        logic       wr_hi;
        logic       wr_ctl;
        logic [7:0] data;
        logic [7:0] ticks;
    } t_tmr_ctl;

    typedef struct packed {
        logic [15:0] counter;
        logic [7:0]  control;
        logic        irq;
    } t_tmr_sts;

endpackage

### rtl/iatr_timer.sv
module iatr_timer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iatr_pkg::t_tmr_ctl i_ctl,
    input  logic               i_irq_en,
    output iatr_pkg::t_tmr_sts o_sts
);

    logic [15:0] r_latch;
    logic [15:0] r_counter;
    logic [7:0]  r_control;
    logic [15:0] n_latch;
    logic [15:0] n_counter;
    logic [7:0]  n_control;
    logic        underflow;
    logic        running;

    assign running   = r_control[iatr_pkg::CTL_START_BIT];
    assign underflow = i_ctl.tick && running && (r_counter <= {8'd0, i_ctl.ticks});

    always_comb begin
        n_latch   = r_latch;
        n_counter = r_counter;
        n_control = r_control;
        if (i_ctl.wr_lo) begin
            n_latch = {r_latch[15:8], i_ctl.data};
        end
        if (i_ctl.wr_hi) begin
            n_latch = {i_ctl.data, r_latch[7:0]};
        end
        if (i_ctl.wr_ctl) begin
            n_control = i_ctl.data;
            if (i_ctl.data[iatr_pkg::CTL_LOAD_BIT]) begin
                n_counter = r_latch;
            end
        end
        if (i_ctl.tick && running) begin
            if (underflow) begin
                if (!r_control[iatr_pkg::CTL_ONESHOT_BIT]) begin
                    n_counter = r_latch;
                end else begin
                    n_counter = 16'd0;
                    n_control[iatr_pkg::CTL_START_BIT] = 1'b0;
                end
            end else begin
                n_counter = r_counter - {8'd0, i_ctl.ticks};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch   <= 16'd0;
            r_counter <= 16'd0;
            r_control <= 8'd0;
        end else begin
            r_latch   <= n_latch;
            r_counter <= n_counter;
            r_control <= n_control;
        end
    end

    assign o_sts.counter = r_counter;
    assign o_sts.control = r_control;
    assign o_sts.irq     = underflow && i_irq_en;

endmodule

### rtl/interface_adapter_timer_regs_unit.sv
// Register file and two 16-bit interval timers of an interface adapter. Each input
// transfer is a bus read, a bus write or a batch of elapsed ticks, and each one
// yields exactly one output transfer carrying the read byte and the interrupt
// request. The block takes one transfer per cycle while its output is not stalled; a
// result is computed from the input register through the single stage of register
// and subtractor logic between that register and the result register.
// While a result waits under stall, the input register holds, so the block keeps at
// most two transfers and then stalls its input.
module interface_adapter_timer_regs_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  iatr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output iatr_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    iatr_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    iatr_pkg::t_out_item r_out_item;

    logic [7:0] r_port_a;
    logic [7:0] r_port_b;
    logic [7:0] r_dir_a;
    logic [7:0] r_dir_b;
    logic [7:0] r_clock_bytes [4];
    logic [7:0] r_serial;
    logic [7:0] r_irq_mask;
    logic [7:0] r_irq_flags;

    logic [7:0] n_port_a;
    logic [7:0] n_port_b;
    logic [7:0] n_irq_mask;
    logic [7:0] n_irq_flags;

    logic                advance;
    logic                work;
    logic                is_rd;
    logic                is_wr;
    logic                is_tick;
    logic [7:0]          rd_data;
    iatr_pkg::t_tmr_ctl  ctl_a;
    iatr_pkg::t_tmr_ctl  ctl_b;
    iatr_pkg::t_tmr_sts  sts_a;
    iatr_pkg::t_tmr_sts  sts_b;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign work       = r_in_valid && advance;
    assign is_rd      = work && (r_in_item.operation == iatr_pkg::OP_READ);
    assign is_wr      = work && (r_in_item.operation == iatr_pkg::OP_WRITE);
    assign is_tick    = work && (r_in_item.operation == iatr_pkg::OP_TICK);

    always_comb begin
        ctl_a.tick   = is_tick;
        ctl_a.wr_lo  = is_wr && (r_in_item.address == iatr_pkg::ADDR_TA_LO);
        ctl_a.wr_hi  = is_wr && (r_in_item.address == iatr_pkg::ADDR_TA_HI);
        ctl_a.wr_ctl = is_wr && (r_in_item.address == iatr_pkg::ADDR_CTRL_A);
        ctl_a.data   = r_in_item.write_data;
        ctl_a.ticks  = r_in_item.tick_count;
        ctl_b.tick   = is_tick;
        ctl_b.wr_lo  = is_wr && (r_in_item.address == iatr_pkg::ADDR_TB_LO);
        ctl_b.wr_hi  = is_wr && (r_in_item.address == iatr_pkg::ADDR_TB_HI);
        ctl_b.wr_ctl = is_wr && (r_in_item.address == iatr_pkg::ADDR_CTRL_B);
        ctl_b.data   = r_in_item.write_data;
        ctl_b.ticks  = r_in_item.tick_count;
    end

    iatr_timer u_timer_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_a),
        .i_irq_en (r_irq_mask[0]),
        .o_sts    (sts_a)
    );

    iatr_timer u_timer_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_b),
        .i_irq_en (r_irq_mask[1]),
        .o_sts    (sts_b)
    );

    always_comb begin
        case (r_in_item.address)
            iatr_pkg::ADDR_PORT_A: rd_data = r_port_a;
            iatr_pkg::ADDR_PORT_B: rd_data = r_port_b;
            iatr_pkg::ADDR_DIR_A:  rd_data = r_dir_a;
            iatr_pkg::ADDR_DIR_B:  rd_data = r_dir_b;
            iatr_pkg::ADDR_TA_LO:  rd_data = sts_a.counter[7:0];
            iatr_pkg::ADDR_TA_HI:  rd_data = sts_a.counter[15:8];
            iatr_pkg::ADDR_TB_LO:  rd_data = sts_b.counter[7:0];
            iatr_pkg::ADDR_TB_HI:  rd_data = sts_b.counter[15:8];
            iatr_pkg::ADDR_CLK_0:  rd_data = r_clock_bytes[0];
            iatr_pkg::ADDR_CLK_1:  rd_data = r_clock_bytes[1];
            iatr_pkg::ADDR_CLK_2:  rd_data = r_clock_bytes[2];
            iatr_pkg::ADDR_CLK_3:  rd_data = r_clock_bytes[3];
            iatr_pkg::ADDR_SERIAL: rd_data = r_serial;
            iatr_pkg::ADDR_ICR:    rd_data = r_irq_flags;
            iatr_pkg::ADDR_CTRL_A: rd_data = sts_a.control;
            default:               rd_data = sts_b.control;
        endcase
    end

    always_comb begin
        n_port_a    = r_port_a;
        n_port_b    = r_port_b;
        n_irq_mask  = r_irq_mask;
        n_irq_flags = r_irq_flags;
        if (is_wr) begin
            case (r_in_item.address)
                iatr_pkg::ADDR_PORT_A: n_port_a = r_in_item.write_data;
                iatr_pkg::ADDR_PORT_B: n_port_b = r_in_item.write_data;
                iatr_pkg::ADDR_DIR_A:  n_port_a = r_port_a | ~r_in_item.write_data;
                iatr_pkg::ADDR_DIR_B:  n_port_b = ~r_in_item.write_data;
                iatr_pkg::ADDR_ICR: begin
                    if (r_in_item.write_data[iatr_pkg::ICR_SET_BIT]) begin
                        n_irq_mask = r_irq_mask | {1'b0, r_in_item.write_data[6:0]};
                    end else begin
                        n_irq_mask = r_irq_mask & ~{1'b0, r_in_item.write_data[6:0]};
                    end
                end
                default: ;
            endcase
        end
        if (is_rd && (r_in_item.address == iatr_pkg::ADDR_ICR)) begin
            n_irq_flags = 8'd0;
        end
        if (sts_a.irq) begin
            n_irq_flags[iatr_pkg::ICR_SET_BIT] = 1'b1;
            n_irq_flags[0] = 1'b1;
        end
        if (sts_b.irq) begin
            n_irq_flags[iatr_pkg::ICR_SET_BIT] = 1'b1;
            n_irq_flags[1] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a         <= 8'd0;
            r_port_b         <= 8'd0;
            r_dir_a          <= 8'd0;
            r_dir_b          <= 8'd0;
            r_clock_bytes[0] <= 8'd0;
            r_clock_bytes[1] <= 8'd0;
            r_clock_bytes[2] <= 8'd0;
            r_clock_bytes[3] <= 8'd0;
            r_serial         <= 8'd0;
            r_irq_mask       <= 8'd0;
            r_irq_flags      <= 8'd0;
        end else begin
            r_port_a    <= n_port_a;
            r_port_b    <= n_port_b;
            r_irq_mask  <= n_irq_mask;
            r_irq_flags <= n_irq_flags;
            if (is_wr) begin
                case (r_in_item.address)
                    iatr_pkg::ADDR_DIR_A:  r_dir_a <= r_in_item.write_data;
                    iatr_pkg::ADDR_DIR_B:  r_dir_b <= r_in_item.write_data;
                    iatr_pkg::ADDR_CLK_0:  r_clock_bytes[0] <= r_in_item.write_data;
                    iatr_pkg::ADDR_CLK_1:  r_clock_bytes[1] <= r_in_item.write_data;
                    iatr_pkg::ADDR_CLK_2:  r_clock_bytes[2] <= r_in_item.write_data;
                    iatr_pkg::ADDR_CLK_3:  r_clock_bytes[3] <= r_in_item.write_data;
                    iatr_pkg::ADDR_SERIAL: r_serial <= r_in_item.write_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (work) begin
            r_out_item.read_data   <= is_rd ? rd_data : 8'd0;
            r_out_item.irq_request <= sts_a.irq || sts_b.irq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
